FILE: hw/rtl/chi_pkg.sv
`timescale 1ns / 1ps

package chi_pkg;

  // Table size and index width
  localparam int unsigned MaxNodes = 8;
  localparam int unsigned IdxW     = $clog2(MaxNodes);
  localparam int unsigned NodeCntW = $clog2(MaxNodes + 1);

  // Field widths
  localparam int unsigned NodeIdxW = 3;
  localparam int unsigned PosW     = 32;
  localparam int unsigned ValW     = 48;
  localparam int unsigned CntW     = 4;
  localparam int unsigned DiffW    = PosW + 1;
  localparam int unsigned WideW    = 64;
  localparam int unsigned ProdW    = 2 * WideW;

  // Stream packing
  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned PosLsb   = NodeIdxW;
  localparam int unsigned ValLsb   = PosLsb + PosW;
  localparam int unsigned SlopeLsb = ValLsb + ValW;
  localparam int unsigned RamW     = 2 * ValW;

  // Queue between front and back
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Arithmetic limits
  localparam logic signed [WideW-1:0] LimitW = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [WideW-1:0] Max48  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [WideW-1:0] Min48  = -64'sh0000_8000_0000_0000;

  // Divider and multiply sequencing
  localparam int unsigned DivCntW = $clog2(WideW);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(WideW - 1);

  typedef enum logic [2:0] {
    OP_HM_LO = 3'd0,
    OP_HM_HI = 3'd1,
    OP_H2    = 3'd2,
    OP_H1    = 3'd3,
    OP_H0    = 3'd4
  } op_e;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_EVAL = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_SAT  = 2'd1,
    STAT_ZERO = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_READ,
    B_DIV,
    B_MUL,
    B_ROUND,
    B_COEF1,
    B_COEF2,
    B_ADD,
    B_FINAL
  } back_state_e;

  // One evaluation request handed from front to back
  typedef struct packed {
    logic signed [DiffW-1:0] h;
    logic signed [DiffW-1:0] dx;
    logic [IdxW-1:0]         k;
  } job_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
    logic back_idle;
  } flow_t;

  typedef struct packed {
    logic signed [WideW-1:0] val;
    logic                    sat;
  } sat_t;

endpackage

FILE: hw/rtl/chi_ram.sv
`timescale 1ns / 1ps

module chi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // One write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: hw/rtl/chi_fifo.sv
`timescale 1ns / 1ps

module chi_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  chi_pkg::job_t wdata_i,
  input  logic          pop_i,
  output chi_pkg::job_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  chi_pkg::job_t                   buf_q [chi_pkg::FifoDepth];
  logic [chi_pkg::FifoPtrW-1:0]    wptr_q, wptr_d;
  logic [chi_pkg::FifoPtrW-1:0]    rptr_q, rptr_d;
  logic [chi_pkg::FifoCntW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == chi_pkg::FifoCntW'(chi_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = buf_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (32'(wptr_q) == chi_pkg::FifoDepth - 1) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (32'(rptr_q) == chi_pkg::FifoDepth - 1) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: hw/rtl/chi_front.sv
`timescale 1ns / 1ps

module chi_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [chi_pkg::InDataW-1:0]          s_axis_tdata_i,
  input  logic                                 s_axis_tuser_i,
  input  logic                                 cfg_we_i,
  input  logic [chi_pkg::CntW-1:0]             cfg_wdata_i,
  input  chi_pkg::flow_t                       flow_i,
  output logic                                 push_o,
  output chi_pkg::job_t                        job_o,
  output logic                                 ram_we_o,
  output logic [chi_pkg::IdxW-1:0]             ram_waddr_o,
  output logic [chi_pkg::RamW-1:0]             ram_wdata_o
);

  logic [chi_pkg::NodeIdxW-1:0]    node_idx;
  logic signed [chi_pkg::PosW-1:0] x;
  logic                            is_eval;
  logic                            accept;
  logic                            slot_ok;

  logic signed [chi_pkg::PosW-1:0] pos_q [chi_pkg::MaxNodes];
  logic [chi_pkg::CntW-1:0]        cnt_q;

  logic [chi_pkg::NodeCntW-1:0]    n_eff;
  logic [chi_pkg::MaxNodes-2:0]    hit;
  logic [chi_pkg::IdxW-1:0]        k;
  logic [chi_pkg::IdxW-1:0]        k_hi;
  logic signed [chi_pkg::PosW-1:0] pos_lo;
  logic signed [chi_pkg::PosW-1:0] pos_hi;

  // Field unpacking
  assign node_idx = s_axis_tdata_i[chi_pkg::NodeIdxW-1:0];
  assign x        = s_axis_tdata_i[chi_pkg::PosLsb +: chi_pkg::PosW];
  assign is_eval  = (s_axis_tuser_i == chi_pkg::REQ_EVAL);
  assign slot_ok  = (32'(node_idx) < chi_pkg::MaxNodes);

  // Queries need queue space; loads wait until every earlier query is done,
  // so that the back end always reads the table as it stood.
  assign s_axis_tready_o = is_eval ? !flow_i.full : (flow_i.empty && flow_i.back_idle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Node count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= chi_pkg::CntW'(2);
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  // Node positions live in flops for the parallel compare.
  always_ff @(posedge clk_i) begin
    if (accept && !is_eval && slot_ok) begin
      pos_q[chi_pkg::IdxW'(node_idx)] <= x;
    end
  end

  // Values and slopes go to the table memory.
  assign ram_we_o    = accept && !is_eval && slot_ok;
  assign ram_waddr_o = chi_pkg::IdxW'(node_idx);
  assign ram_wdata_o = {s_axis_tdata_i[chi_pkg::SlopeLsb +: chi_pkg::ValW],
                        s_axis_tdata_i[chi_pkg::ValLsb +: chi_pkg::ValW]};

  // Interval search: the first upper node at or above the query position.
  always_comb begin
    n_eff = chi_pkg::NodeCntW'(cnt_q);
    if (cnt_q < chi_pkg::CntW'(2)) begin
      n_eff = chi_pkg::NodeCntW'(2);
    end else if (32'(cnt_q) > chi_pkg::MaxNodes) begin
      n_eff = chi_pkg::NodeCntW'(chi_pkg::MaxNodes);
    end
    for (int i = 0; i < chi_pkg::MaxNodes - 1; i++) begin
      hit[i] = (x <= pos_q[i+1]) && ((i + 1) < 32'(n_eff));
    end
    k = chi_pkg::IdxW'(n_eff - chi_pkg::NodeCntW'(2));
    for (int i = chi_pkg::MaxNodes - 2; i >= 0; i--) begin
      if (hit[i]) begin
        k = chi_pkg::IdxW'(i);
      end
    end
  end

  assign k_hi   = k + 1'b1;
  assign pos_lo = pos_q[k];
  assign pos_hi = pos_q[k_hi];

  // Exact 33-bit differences for the back end.
  assign job_o.h  = {pos_hi[chi_pkg::PosW-1], pos_hi} - {pos_lo[chi_pkg::PosW-1], pos_lo};
  assign job_o.dx = {x[chi_pkg::PosW-1], x} - {pos_lo[chi_pkg::PosW-1], pos_lo};
  assign job_o.k  = k;
  assign push_o   = accept && is_eval;

endmodule

FILE: hw/rtl/chi_back.sv
`timescale 1ns / 1ps

module chi_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  chi_pkg::job_t                    job_i,
  input  logic                             empty_i,
  output logic                             pop_o,
  output logic                             idle_o,
  output logic [chi_pkg::IdxW-1:0]         raddr_a_o,
  output logic [chi_pkg::IdxW-1:0]         raddr_b_o,
  input  logic [chi_pkg::RamW-1:0]         rdata_a_i,
  input  logic [chi_pkg::RamW-1:0]         rdata_b_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [chi_pkg::OutDataW-1:0]     m_axis_tdata_o
);

  localparam int unsigned W = chi_pkg::WideW;

  chi_pkg::back_state_e state_q, state_d;
  chi_pkg::op_e         op_q, op_d;

  logic signed [chi_pkg::DiffW-1:0] h_q, h_d, dx_q, dx_d;
  logic signed [chi_pkg::ValW-1:0]  ylo_q, ylo_d, yhi_q, yhi_d;
  logic signed [chi_pkg::ValW-1:0]  mlo_q, mlo_d, mhi_q, mhi_d;
  logic [W-1:0]                     num_q, num_d;
  logic [chi_pkg::DiffW:0]          rem_q, rem_d;
  logic [chi_pkg::DivCntW-1:0]      div_cnt_q, div_cnt_d;
  logic                             tneg_q, tneg_d;
  logic [chi_pkg::ProdW-1:0]        prod_q, prod_d;
  logic [1:0]                       pp_cnt_q, pp_cnt_d;
  logic signed [W-1:0]              p_q, p_d, acc_q, acc_d;
  logic signed [W-1:0]              hm0_q, hm0_d, hm1_q, hm1_d;
  logic signed [W-1:0]              c2_q, c2_d, c3_q, c3_d;
  logic                             sat_q, sat_d, zw_q, zw_d;
  logic                             ovld_q, ovld_d;
  logic signed [chi_pkg::ValW-1:0]  oval_q, oval_d;
  chi_pkg::status_e                 ostat_q, ostat_d;

  // Combinational helpers
  logic [chi_pkg::DiffW-1:0]        mag_h, mag_dx;
  logic [chi_pkg::DiffW:0]          rem_sh;
  logic                             qbit;
  logic signed [W-1:0]              opa, opb_s;
  logic [W-1:0]                     mag_a, mag_b;
  logic                             neg_p;
  logic [31:0]                      part_a, part_b;
  logic [W-1:0]                     pp;
  logic [6:0]                       pp_sh;
  logic [chi_pkg::ProdW-1:0]        rnd, qwide;
  logic                             rsat;
  logic signed [W-1:0]              qval, pres;
  logic signed [W-1:0]              d, d3, nd2, addend;
  chi_pkg::sat_t                    sa, sb, sc;
  logic                             clamp;

  // Sum of two operands within the limit, clamped to +-LimitW.
  function automatic chi_pkg::sat_t add_sat(input logic signed [W-1:0] a,
                                            input logic signed [W-1:0] b);
    logic signed [W-1:0] s;
    chi_pkg::sat_t       r;
    s     = a + b;
    r.val = s;
    r.sat = 1'b0;
    if (s > chi_pkg::LimitW) begin
      r.val = chi_pkg::LimitW;
      r.sat = 1'b1;
    end else if (s < -chi_pkg::LimitW) begin
      r.val = -chi_pkg::LimitW;
      r.sat = 1'b1;
    end
    return r;
  endfunction

  assign idle_o          = (state_q == chi_pkg::B_IDLE);
  assign raddr_a_o       = job_i.k;
  assign raddr_b_o       = job_i.k + 1'b1;
  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = {{(chi_pkg::OutDataW - chi_pkg::ValW - 2){1'b0}}, ostat_q, oval_q};

  // Magnitudes for the divider
  assign mag_h  = h_q[chi_pkg::DiffW-1] ? chi_pkg::DiffW'(-h_q) : chi_pkg::DiffW'(h_q);
  assign mag_dx = dx_q[chi_pkg::DiffW-1] ? chi_pkg::DiffW'(-dx_q) : chi_pkg::DiffW'(dx_q);

  // One restoring division step.
  assign rem_sh = {rem_q[chi_pkg::DiffW-1:0], num_q[W-1]};
  assign qbit   = (rem_sh >= {1'b0, mag_h});

  // Multiplier operand selection per operation.
  always_comb begin
    if (op_q == chi_pkg::OP_HM_LO || op_q == chi_pkg::OP_HM_HI) begin
      opa   = W'(h_q);
      opb_s = (op_q == chi_pkg::OP_HM_LO) ? W'(mlo_q) : W'(mhi_q);
      mag_b = opb_s[W-1] ? W'(-opb_s) : W'(opb_s);
      neg_p = opa[W-1] ^ opb_s[W-1];
    end else begin
      opa   = acc_q;
      opb_s = '0;
      mag_b = num_q;
      neg_p = acc_q[W-1] ^ tneg_q;
    end
    mag_a = opa[W-1] ? W'(-opa) : W'(opa);
  end

  // 32x32 partial product; four of them are summed into the 128-bit product.
  assign part_a = pp_cnt_q[0] ? mag_a[W-1:32] : mag_a[31:0];
  assign part_b = pp_cnt_q[1] ? mag_b[W-1:32] : mag_b[31:0];
  assign pp     = part_a * part_b;
  assign pp_sh  = {pp_cnt_q[0] & pp_cnt_q[1], pp_cnt_q[0] ^ pp_cnt_q[1], 5'b0};

  // Rounding, shift and clamp of the finished product.
  always_comb begin
    if (op_q == chi_pkg::OP_HM_LO || op_q == chi_pkg::OP_HM_HI) begin
      rnd   = prod_q + (chi_pkg::ProdW'(1) << 15);
      qwide = rnd >> 16;
    end else begin
      rnd   = prod_q + (chi_pkg::ProdW'(1) << 29);
      qwide = rnd >> 30;
    end
    rsat = |qwide[chi_pkg::ProdW-1:62];
    qval = rsat ? chi_pkg::LimitW : W'(qwide[W-1:0]);
    pres = neg_p ? -qval : qval;
  end

  // Coefficient terms
  assign d   = W'(yhi_q) - W'(ylo_q);
  assign d3  = d + (d <<< 1);
  assign nd2 = -(d <<< 1);

  always_comb begin
    case (op_q)
      chi_pkg::OP_H2: addend = c2_q;
      chi_pkg::OP_H1: addend = hm0_q;
      default:        addend = W'(ylo_q);
    endcase
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    h_d       = h_q;
    dx_d      = dx_q;
    ylo_d     = ylo_q;
    yhi_d     = yhi_q;
    mlo_d     = mlo_q;
    mhi_d     = mhi_q;
    num_d     = num_q;
    rem_d     = rem_q;
    div_cnt_d = div_cnt_q;
    tneg_d    = tneg_q;
    prod_d    = prod_q;
    pp_cnt_d  = pp_cnt_q;
    p_d       = p_q;
    acc_d     = acc_q;
    hm0_d     = hm0_q;
    hm1_d     = hm1_q;
    c2_d      = c2_q;
    c3_d      = c3_q;
    sat_d     = sat_q;
    zw_d      = zw_q;
    ovld_d    = ovld_q && !m_axis_tready_i;
    oval_d    = oval_q;
    ostat_d   = ostat_q;
    pop_o     = 1'b0;
    sa        = add_sat(d3, -hm0_q);
    sb        = add_sat(-hm0_q, -hm1_q);
    sc        = add_sat(hm0_q, hm1_q);
    clamp     = 1'b0;

    case (state_q)
      chi_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          h_d     = job_i.h;
          dx_d    = job_i.dx;
          sat_d   = 1'b0;
          zw_d    = 1'b0;
          op_d    = chi_pkg::OP_HM_LO;
          state_d = chi_pkg::B_READ;
        end
      end
      chi_pkg::B_READ: begin
        ylo_d  = rdata_a_i[chi_pkg::ValW-1:0];
        mlo_d  = rdata_a_i[chi_pkg::RamW-1:chi_pkg::ValW];
        yhi_d  = rdata_b_i[chi_pkg::ValW-1:0];
        mhi_d  = rdata_b_i[chi_pkg::RamW-1:chi_pkg::ValW];
        tneg_d = dx_q[chi_pkg::DiffW-1] ^ h_q[chi_pkg::DiffW-1];
        if (h_q == '0) begin
          zw_d    = 1'b1;
          state_d = chi_pkg::B_FINAL;
        end else begin
          num_d     = (W'(mag_dx) << 30) + W'(mag_h >> 1);
          rem_d     = '0;
          div_cnt_d = '0;
          state_d   = chi_pkg::B_DIV;
        end
      end
      chi_pkg::B_DIV: begin
        rem_d     = qbit ? (rem_sh - {1'b0, mag_h}) : rem_sh;
        num_d     = {num_q[W-2:0], qbit};
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == chi_pkg::DivLast) begin
          prod_d   = '0;
          pp_cnt_d = '0;
          state_d  = chi_pkg::B_MUL;
        end
      end
      chi_pkg::B_MUL: begin
        prod_d   = prod_q + (chi_pkg::ProdW'(pp) << pp_sh);
        pp_cnt_d = pp_cnt_q + 1'b1;
        if (pp_cnt_q == 2'd3) begin
          state_d = chi_pkg::B_ROUND;
        end
      end
      chi_pkg::B_ROUND: begin
        sat_d = sat_q | rsat;
        case (op_q)
          chi_pkg::OP_HM_LO: begin
            hm0_d    = pres;
            op_d     = chi_pkg::OP_HM_HI;
            prod_d   = '0;
            pp_cnt_d = '0;
            state_d  = chi_pkg::B_MUL;
          end
          chi_pkg::OP_HM_HI: begin
            hm1_d   = pres;
            state_d = chi_pkg::B_COEF1;
          end
          default: begin
            p_d     = pres;
            state_d = chi_pkg::B_ADD;
          end
        endcase
      end
      chi_pkg::B_COEF1: begin
        // Partial sums of the two upper coefficients.
        c2_d    = sa.val;
        p_d     = sb.val;
        c3_d    = sc.val;
        sat_d   = sat_q | sa.sat | sb.sat | sc.sat;
        state_d = chi_pkg::B_COEF2;
      end
      chi_pkg::B_COEF2: begin
        sa       = add_sat(c2_q, p_q);
        sb       = add_sat(nd2, c3_q);
        c2_d     = sa.val;
        acc_d    = sb.val;
        sat_d    = sat_q | sa.sat | sb.sat;
        op_d     = chi_pkg::OP_H2;
        prod_d   = '0;
        pp_cnt_d = '0;
        state_d  = chi_pkg::B_MUL;
      end
      chi_pkg::B_ADD: begin
        // Horner step: product plus the next coefficient.
        sa    = add_sat(p_q, addend);
        acc_d = sa.val;
        sat_d = sat_q | sa.sat;
        if (op_q == chi_pkg::OP_H0) begin
          state_d = chi_pkg::B_FINAL;
        end else begin
          op_d     = (op_q == chi_pkg::OP_H2) ? chi_pkg::OP_H1 : chi_pkg::OP_H0;
          prod_d   = '0;
          pp_cnt_d = '0;
          state_d  = chi_pkg::B_MUL;
        end
      end
      chi_pkg::B_FINAL: begin
        if (!ovld_q || m_axis_tready_i) begin
          ovld_d = 1'b1;
          if (zw_q) begin
            oval_d  = '0;
            ostat_d = chi_pkg::STAT_ZERO;
          end else begin
            oval_d = chi_pkg::ValW'(acc_q);
            if (acc_q > chi_pkg::Max48) begin
              oval_d = chi_pkg::ValW'(chi_pkg::Max48);
              clamp  = 1'b1;
            end else if (acc_q < chi_pkg::Min48) begin
              oval_d = chi_pkg::ValW'(chi_pkg::Min48);
              clamp  = 1'b1;
            end
            ostat_d = (sat_q || clamp) ? chi_pkg::STAT_SAT : chi_pkg::STAT_OK;
          end
          state_d = chi_pkg::B_IDLE;
        end
      end
      default: state_d = chi_pkg::B_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chi_pkg::B_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    h_q       <= h_d;
    dx_q      <= dx_d;
    ylo_q     <= ylo_d;
    yhi_q     <= yhi_d;
    mlo_q     <= mlo_d;
    mhi_q     <= mhi_d;
    num_q     <= num_d;
    rem_q     <= rem_d;
    div_cnt_q <= div_cnt_d;
    tneg_q    <= tneg_d;
    prod_q    <= prod_d;
    pp_cnt_q  <= pp_cnt_d;
    p_q       <= p_d;
    acc_q     <= acc_d;
    hm0_q     <= hm0_d;
    hm1_q     <= hm1_d;
    c2_q      <= c2_d;
    c3_q      <= c3_d;
    sat_q     <= sat_d;
    zw_q      <= zw_d;
    oval_q    <= oval_d;
    ostat_q   <= ostat_d;
  end

  // A zero-width interval always delivers a zero value.
  a_zero_width_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && ostat_q == chi_pkg::STAT_ZERO) |-> (oval_q == '0))
    else $error("zero-width result carries a non-zero value");

  // The sequencer leaves idle only by taking a queued request.
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chi_pkg::B_IDLE && empty_i) |=> (state_q == chi_pkg::B_IDLE))
    else $error("back end left idle without a request");

  // The divider runs its full count of steps.
  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chi_pkg::B_DIV && div_cnt_q != chi_pkg::DivLast) |=>
    (state_q == chi_pkg::B_DIV))
    else $error("divider stopped early");

  // A result register that is full and stalled is never overwritten.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && !m_axis_tready_i) |=> $stable(oval_q) && $stable(ostat_q))
    else $error("stalled result overwritten");

endmodule

FILE: hw/rtl/cubic_hermite_interpolator.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                       Contents
// s_axis    in   tvalid/tready/tdata/tuser     load node or evaluate request
// m_axis    out  tvalid/tready/tdata           interpolated value and status
// cfg       in   cfg_we_i/cfg_wdata_i          node count register
//
// A load waits until all earlier queries have finished.
// A query in the back end runs the 64-step restoring divider and five
// 64x64 products, each built from four 32x32 steps.
// A two-entry queue lets the front take queries while the back end works.
// Reset is asynchronous, active low; the node table holds no reset value.
// The result register lets the next query proceed while a result is stalled.

module cubic_hermite_interpolator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: node_index[2:0], position[34:3], node_value[82:35],
  // node_slope[130:83], zero fill above
  input  logic [chi_pkg::InDataW-1:0]      s_axis_tdata,
  // tuser: req_type
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: interpolated[47:0], status[49:48], zero fill above
  output logic [chi_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [chi_pkg::CntW-1:0]         cfg_wdata_i
);

  chi_pkg::job_t              job_in, job_out;
  chi_pkg::flow_t             flow;
  logic                       push, pop, full, empty, back_idle;
  logic                       ram_we;
  logic [chi_pkg::IdxW-1:0]   ram_waddr, raddr_a, raddr_b;
  logic [chi_pkg::RamW-1:0]   ram_wdata, rdata_a, rdata_b;

  assign flow.full      = full;
  assign flow.empty     = empty;
  assign flow.back_idle = back_idle;

  chi_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .flow_i          (flow),
    .push_o          (push),
    .job_o           (job_in),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata)
  );

  chi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_in),
    .pop_i   (pop),
    .rdata_o (job_out),
    .full_o  (full),
    .empty_o (empty)
  );

  chi_ram #(
    .Width (chi_pkg::RamW),
    .Depth (chi_pkg::MaxNodes)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  chi_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (job_out),
    .empty_i         (empty),
    .pop_o           (pop),
    .idle_o          (back_idle),
    .raddr_a_o       (raddr_a),
    .raddr_b_o       (raddr_b),
    .rdata_a_i       (rdata_a),
    .rdata_b_i       (rdata_b),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

endmodule
